// File: design/voxel_tile_cluster_adjacency_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the voxel tile cluster adjacency block
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_TILE_CLUSTER_ADJACENCY_MACROS_SVH
`define VOXEL_TILE_CLUSTER_ADJACENCY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTCA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VTCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/vtca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtca_pkg
// Types, sizes and codes shared by the voxel tile cluster adjacency block.
// ----------------------------------------------------------------------------
package vtca_pkg;

	localparam int MAX_TILES    = 256;
	localparam int NEIGHBOR_PAD = 1;

	localparam int COORD_W  = 16;
	localparam int KIND_W   = 2;
	localparam int MODE_W   = 2;
	localparam int COUNT_W  = 9;
	localparam int CNT_W    = $clog2(MAX_TILES + 1);
	localparam int ADDR_W   = $clog2(MAX_TILES);
	localparam int BOX_W    = COORD_W + 2;
	localparam int AXES     = 3;

	typedef logic signed [COORD_W-1:0] vtca_coord_t;
	typedef vtca_coord_t [AXES-1:0] vtca_tile_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_QUERY   = 2'd0,
		KIND_ADD     = 2'd1,
		KIND_RESTART = 2'd2
	} vtca_kind_t;

	localparam logic [MODE_W-1:0] CONN_FACE   = 2'd0;
	localparam logic [MODE_W-1:0] CONN_EDGE   = 2'd1;
	localparam logic [MODE_W-1:0] CONN_CORNER = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} vtca_state_t;

	typedef struct packed {
		logic latch;
		logic seed;
		logic append;
		logic set_ovf;
		logic scan_rd;
		logic load_out;
	} vtca_cmd_t;

	typedef struct packed {
		vtca_kind_t kind;
		logic       empty;
		logic       full;
		logic       in_box;
		logic       scan_last;
	} vtca_sts_t;

	typedef struct packed {
		logic               is_connected;
		logic               overflow;
		logic [COUNT_W-1:0] tile_count;
		vtca_tile_t         box_min;
		vtca_tile_t         box_max;
	} vtca_result_t;

endpackage

// File: design/vtca_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtca channel interfaces
// Valid/ready channels for input items, results and the mode register.
// ----------------------------------------------------------------------------
interface vtca_item_if;
	import vtca_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [COORD_W-1:0] tile_x;
	logic signed [COORD_W-1:0] tile_y;
	logic signed [COORD_W-1:0] tile_z;
	modport source (output valid, kind, tile_x, tile_y, tile_z, input ready);
	modport sink   (input valid, kind, tile_x, tile_y, tile_z, output ready);
endinterface

interface vtca_result_if;
	import vtca_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      is_connected;
	logic                      overflow;
	logic [COUNT_W-1:0]        tile_count;
	logic signed [COORD_W-1:0] box_min_x;
	logic signed [COORD_W-1:0] box_min_y;
	logic signed [COORD_W-1:0] box_min_z;
	logic signed [COORD_W-1:0] box_max_x;
	logic signed [COORD_W-1:0] box_max_y;
	logic signed [COORD_W-1:0] box_max_z;
	modport source (output valid, is_connected, overflow, tile_count, box_min_x, box_min_y,
		box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink   (input valid, is_connected, overflow, tile_count, box_min_x, box_min_y,
		box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface vtca_cfg_if;
	import vtca_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] conn_mode;
	modport source (output valid, conn_mode, input ready);
	modport sink   (input valid, conn_mode, output ready);
endinterface

// File: design/vtca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtca_ctrl
// Sequencer: accepts an item, runs the update or the store scan, and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module vtca_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  vtca_pkg::vtca_sts_t sts,
	output vtca_pkg::vtca_cmd_t cmd
);
	import vtca_pkg::*;

	vtca_state_t state_q, state_nxt;
	logic        out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_DONE;
				case (sts.kind)
					KIND_QUERY: begin
						// An empty cluster or a tile outside the padded box never connects.
						if (!sts.empty && sts.in_box) begin
							state_nxt = ST_SCAN;
						end
					end
					KIND_ADD: begin
						if (sts.empty) begin
							cmd.seed = 1'b1;
						end else if (sts.full) begin
							cmd.set_ovf = 1'b1;
						end else begin
							cmd.append = 1'b1;
						end
					end
					KIND_RESTART: begin
						cmd.seed = 1'b1;
					end
					default: begin
					end
				endcase
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_vld_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_vld_q;

endmodule

// File: design/vtca_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtca_dp
// Tile store, bounding box, neighbour compare and result register.
// ----------------------------------------------------------------------------
module vtca_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [vtca_pkg::MODE_W-1:0]  cfg_mode,
	input  logic [vtca_pkg::KIND_W-1:0]  item_kind,
	input  vtca_pkg::vtca_tile_t         item_tile,
	input  vtca_pkg::vtca_cmd_t          cmd,
	output vtca_pkg::vtca_sts_t          sts,
	output vtca_pkg::vtca_result_t       res
);
	import vtca_pkg::*;

	vtca_tile_t         mem [MAX_TILES];

	vtca_kind_t         kind_q;
	vtca_tile_t         tile_q;
	vtca_tile_t         lo_q, hi_q, lo_nxt, hi_nxt;
	logic [CNT_W-1:0]   count_q;
	logic [MODE_W-1:0]  mode_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [ADDR_W-1:0]  wr_addr;
	logic               hit_q, ovf_q;
	logic               rd_vld_s1;
	vtca_tile_t         rd_data_s1;
	vtca_result_t       res_q;

	logic               in_box, is_nbr, all_near;
	logic [1:0]         moved;
	logic [AXES-1:0]    near, nz, box_ok;

	// Padded bounding box test and min/max widening, one lane per axis.
	always_comb begin
		logic signed [BOX_W-1:0] t_ext, lo_ext, hi_ext;
		for (int k = 0; k < AXES; k++) begin
			t_ext     = BOX_W'(signed'(tile_q[k]));
			lo_ext    = BOX_W'(signed'(lo_q[k])) - BOX_W'(NEIGHBOR_PAD);
			hi_ext    = BOX_W'(signed'(hi_q[k])) + BOX_W'(NEIGHBOR_PAD);
			box_ok[k] = (t_ext >= lo_ext) && (t_ext <= hi_ext);
			lo_nxt[k] = (signed'(tile_q[k]) < signed'(lo_q[k])) ? tile_q[k] : lo_q[k];
			hi_nxt[k] = (signed'(tile_q[k]) > signed'(hi_q[k])) ? tile_q[k] : hi_q[k];
		end
		in_box = &box_ok;
	end

	// Neighbour test of the stored tile just read against the query tile.
	always_comb begin
		logic signed [COORD_W:0] d;
		for (int k = 0; k < AXES; k++) begin
			d       = (COORD_W+1)'(signed'(rd_data_s1[k])) - (COORD_W+1)'(signed'(tile_q[k]));
			nz[k]   = (d != '0);
			near[k] = (d == '0) || (d == (COORD_W+1)'(1)) || (d == -(COORD_W+1)'(1));
		end
		all_near = &near;
		moved    = 2'({1'b0, nz[0]}) + 2'({1'b0, nz[1]}) + 2'({1'b0, nz[2]});
		case (mode_q)
			CONN_FACE:   is_nbr = all_near && (moved == 2'd1);
			CONN_EDGE:   is_nbr = all_near && (moved != 2'd0) && (moved != 2'd3);
			CONN_CORNER: is_nbr = all_near && (moved != 2'd0);
			default:     is_nbr = 1'b0;
		endcase
	end

	assign wr_addr = cmd.seed ? '0 : count_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.seed || cmd.append) begin
			mem[wr_addr] <= tile_q;
		end
		if (cmd.scan_rd) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= vtca_kind_t'(item_kind);
			tile_q <= item_tile;
		end
		if (cmd.load_out) begin
			res_q.is_connected <= hit_q;
			res_q.overflow     <= ovf_q;
			res_q.tile_count   <= COUNT_W'(count_q);
			res_q.box_min      <= lo_q;
			res_q.box_max      <= hi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			mode_q    <= CONN_FACE;
			idx_q     <= '0;
			hit_q     <= 1'b0;
			ovf_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_mode;
			end
			if (cmd.seed) begin
				lo_q    <= tile_q;
				hi_q    <= tile_q;
				count_q <= CNT_W'(1);
			end else if (cmd.append) begin
				lo_q    <= lo_nxt;
				hi_q    <= hi_nxt;
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.latch) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					idx_q <= idx_q + ADDR_W'(1);
				end
				if (rd_vld_s1 && is_nbr) begin
					hit_q <= 1'b1;
				end
				if (cmd.set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
			rd_vld_s1 <= cmd.scan_rd;
		end
	end

	assign sts.kind      = kind_q;
	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CNT_W'(MAX_TILES));
	assign sts.in_box    = in_box;
	assign sts.scan_last = (idx_q == ADDR_W'(count_q - CNT_W'(1)));
	assign res           = res_q;

endmodule

// File: design/voxel_tile_cluster_adjacency.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_tile_cluster_adjacency
// Keeps a cluster of 3D tile indices with its bounding box and answers
// whether a tile is a 6-, 18- or 26-neighbour of the cluster.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   item      in         kind, tile_x, tile_y, tile_z
//   result    out        is_connected, overflow, tile_count, box_min_*, box_max_*
//   cfg       in         conn_mode (always ready)
//
// An add, a restart or an unused kind passes from the accept through the
// execute state to the done state, which loads the output register. A query
// of a non-empty cluster inside the padded box also runs a scan of the tile
// store through its single read port, one tile per cycle for up to MAX_TILES
// tiles, and a drain state; any other query skips the scan. The done state
// waits while the output register holds a result not yet taken. The next item
// is accepted as soon as the previous result sits in the output register,
// even while that result waits on result.ready.
// Reset empties the cluster, zeroes the box and selects 6-connectivity.
//
module voxel_tile_cluster_adjacency (
	input logic clk,
	input logic arst_n,
	vtca_cfg_if.sink    cfg,
	vtca_item_if.sink   item,
	vtca_result_if.source result
);
	import vtca_pkg::*;

	`include "voxel_tile_cluster_adjacency_macros.svh"

	vtca_cmd_t    cmd;
	vtca_sts_t    sts;
	vtca_result_t res;
	vtca_tile_t   item_tile;

	// Tile coordinates travel as one packed vector, x in the lowest lane.
	assign item_tile[0] = item.tile_x;
	assign item_tile[1] = item.tile_y;
	assign item_tile[2] = item.tile_z;

	// The mode register can take a write in any cycle.
	assign cfg.ready = 1'b1;

	vtca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	vtca_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid),
		.cfg_mode  (cfg.conn_mode),
		.item_kind (item.kind),
		.item_tile (item_tile),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

	// Unpack the registered result onto the output transaction.
	assign result.is_connected = res.is_connected;
	assign result.overflow     = res.overflow;
	assign result.tile_count   = res.tile_count;
	assign result.box_min_x    = res.box_min[0];
	assign result.box_min_y    = res.box_min[1];
	assign result.box_min_z    = res.box_min[2];
	assign result.box_max_x    = res.box_max[0];
	assign result.box_max_y    = res.box_max[1];
	assign result.box_max_z    = res.box_max[2];

	// A dropped add can only happen with the store full.
	`VTCA_ASSERT_SAME(a_ovf_full, clk, arst_n, result.valid && result.overflow, result.tile_count == COUNT_W'(MAX_TILES), "overflow reported without a full store")
	// A query answer and an overflow never come from the same item.
	`VTCA_ASSERT_SAME(a_excl, clk, arst_n, result.valid, !(result.is_connected && result.overflow), "connected and overflow both set")
	// An empty cluster never connects.
	`VTCA_ASSERT_SAME(a_empty, clk, arst_n, result.valid && (result.tile_count == '0), !result.is_connected, "empty cluster reported connected")
	// After an accepted transaction the input stays closed while the item is worked on.
	`VTCA_ASSERT_NEXT(a_busy, clk, arst_n, item.valid && item.ready, !item.ready, "input reopened in the cycle after an accept")

endmodule
